[rtl/lrukv_pkg.sv]
package lrukv_pkg;

	localparam int ENTRIES_DEFAULT = 16;
	localparam int CAP_W           = 5;
	localparam int KEY_W           = 32;
	localparam int VAL_W           = 32;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	typedef enum logic {
		OP_GET = 1'b0,
		OP_PUT = 1'b1
	} opcode_t;

	typedef struct packed {
		opcode_t            opcode;
		logic [KEY_W-1:0]   lookup_key;
		logic [VAL_W-1:0]   write_value;
	} req_t;

	typedef struct packed {
		logic               hit;
		logic [VAL_W-1:0]   read_value;
		logic               evicted;
		logic [KEY_W-1:0]   evicted_key;
	} result_t;

endpackage

[rtl/lru_key_value_cache.sv]
// channel   dir  beat content (low bit up)
// s_axis    in   tdata 64: lookup_key, write_value; tuser 1: opcode
// m_axis    out  tdata 64: read_value, evicted_key; tuser 2: hit, evicted
// cfg       in   data 5: cache_capacity
//
// one beat per cycle in both directions while m_axis is not stalled; the input
// beat lands in the input register, and its result is then registered in the
// result register and offered on m_axis from there
// the whole lookup, lru victim pick and rank update sit between those two
// registers, so back-to-back operations see each other's updates
// arst_n clears valid marks, fill count, capacity (to 16) and beat valids
// a stalled m_axis holds the result; one more beat waits in the input stage
module lru_key_value_cache #(
	parameter int ENTRIES = lrukv_pkg::ENTRIES_DEFAULT
) (
	input  logic                         clk,
	input  logic                         arst_n,

	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	input  logic [63:0]                  s_axis_tdata,  // lookup_key, write_value
	input  logic [0:0]                   s_axis_tuser,  // opcode

	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	output logic [63:0]                  m_axis_tdata,  // read_value, evicted_key
	output logic [1:0]                   m_axis_tuser,  // hit, evicted

	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [lrukv_pkg::CAP_W-1:0]  cfg_data
);

	logic [lrukv_pkg::CAP_W-1:0]  cache_capacity_q;
	lrukv_pkg::req_t              req_s1;
	logic                         valid_s1;
	lrukv_pkg::result_t           res_comb;
	lrukv_pkg::result_t           res_s2;
	logic                         valid_s2;
	logic                         advance;
	logic                         fire;
	logic                         in_beat;

	// capacity register, always writable
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cache_capacity_q <= lrukv_pkg::CAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			cache_capacity_q <= cfg_data;
		end
	end

	// stage 1 moves on whenever the result register is free or being drained
	assign advance       = !valid_s2 || m_axis_tready;
	assign fire          = valid_s1 && advance;
	assign s_axis_tready = !valid_s1 || advance;
	assign in_beat       = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk) begin
		if (in_beat) begin
			req_s1.opcode      <= lrukv_pkg::opcode_t'(s_axis_tuser[0]);
			req_s1.lookup_key  <= s_axis_tdata[31:0];
			req_s1.write_value <= s_axis_tdata[63:32];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_beat) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	// tag store, lookup and lru update
	lrukv_store #(
		.ENTRIES (ENTRIES)
	) u_store (
		.clk            (clk),
		.arst_n         (arst_n),
		.fire           (fire),
		.req            (req_s1),
		.cache_capacity (cache_capacity_q),
		.result         (res_comb)
	);

	// result register
	always_ff @(posedge clk) begin
		if (fire) begin
			res_s2 <= res_comb;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (fire) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {res_s2.evicted_key, res_s2.read_value};
	assign m_axis_tuser  = {res_s2.evicted, res_s2.hit};

endmodule

[rtl/lrukv_store.sv]
module lrukv_store #(
	parameter int ENTRIES = lrukv_pkg::ENTRIES_DEFAULT
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           fire,
	input  lrukv_pkg::req_t                req,
	input  logic [lrukv_pkg::CAP_W-1:0]    cache_capacity,
	output lrukv_pkg::result_t             result
);

	localparam int RW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW = $clog2(ENTRIES + 1);
	localparam int EW = (CW > lrukv_pkg::CAP_W) ? CW : lrukv_pkg::CAP_W;

	logic [ENTRIES-1:0]            valid_q;
	logic [lrukv_pkg::KEY_W-1:0]   key_q  [ENTRIES];
	logic [lrukv_pkg::VAL_W-1:0]   data_q [ENTRIES];
	logic [RW-1:0]                 rank_q [ENTRIES];
	logic [RW-1:0]                 rank_d [ENTRIES];
	logic [CW-1:0]                 count_q;

	logic [ENTRIES-1:0]            match;
	logic [ENTRIES-1:0]            victim_vec;
	logic [ENTRIES-1:0]            free_vec;
	logic [ENTRIES-1:0]            hit_sel;
	logic [ENTRIES-1:0]            victim_sel;
	logic [ENTRIES-1:0]            free_sel;
	logic [ENTRIES-1:0]            sel;
	logic [EW-1:0]                 cap_eff;
	logic                          found;
	logic                          is_put;
	logic                          full;
	logic                          do_evict;
	logic                          do_fill;
	logic                          install;
	logic [RW-1:0]                 r_hit;
	logic [lrukv_pkg::VAL_W-1:0]   rd;
	logic [lrukv_pkg::KEY_W-1:0]   evk;

	// parallel key compare and rank decode
	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			match[i]      = valid_q[i] && (key_q[i] == req.lookup_key);
			victim_vec[i] = valid_q[i] && ((CW'(rank_q[i]) + CW'(1)) == count_q);
		end
		free_vec   = ~valid_q;
		hit_sel    = match & (~match + ENTRIES'(1));
		victim_sel = victim_vec & (~victim_vec + ENTRIES'(1));
		free_sel   = free_vec & (~free_vec + ENTRIES'(1));
	end

	// clamp capacity to 1..ENTRIES
	always_comb begin
		cap_eff = EW'(cache_capacity);
		if (cap_eff == EW'(0)) begin
			cap_eff = EW'(1);
		end else if (cap_eff > EW'(ENTRIES)) begin
			cap_eff = EW'(ENTRIES);
		end
	end

	always_comb begin
		found    = |match;
		is_put   = (req.opcode == lrukv_pkg::OP_PUT);
		full     = (EW'(count_q) >= cap_eff);
		do_evict = is_put && !found && full;
		do_fill  = is_put && !found && !full && (|free_vec);
		install  = do_evict || do_fill;

		priority if (found) begin
			sel = hit_sel;
		end else if (do_evict) begin
			sel = victim_sel;
		end else if (do_fill) begin
			sel = free_sel;
		end else begin
			sel = '0;
		end

		r_hit = '0;
		rd    = '0;
		evk   = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			r_hit = r_hit | (hit_sel[i] ? rank_q[i] : '0);
			rd    = rd | (hit_sel[i] ? data_q[i] : '0);
			evk   = evk | (victim_sel[i] ? key_q[i] : '0);
		end

		// selected slot becomes most recent, younger valid slots age by one
		for (int i = 0; i < ENTRIES; i++) begin
			if (sel[i]) begin
				rank_d[i] = '0;
			end else if (valid_q[i] && (install || (rank_q[i] < r_hit))) begin
				rank_d[i] = rank_q[i] + RW'(1);
			end else begin
				rank_d[i] = rank_q[i];
			end
		end

		result.hit         = found;
		result.read_value  = (!is_put && found) ? rd : '0;
		result.evicted     = do_evict;
		result.evicted_key = do_evict ? evk : '0;
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			for (int i = 0; i < ENTRIES; i++) begin
				rank_q[i] <= rank_d[i];
				if (sel[i] && is_put) begin
					data_q[i] <= req.write_value;
				end
				if (sel[i] && install) begin
					key_q[i] <= req.lookup_key;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
		end else if (fire && do_fill) begin
			valid_q <= valid_q | free_sel;
			count_q <= count_q + CW'(1);
		end
	end

	// fill count tracks the number of valid slots
	a_count_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == int'(count_q))
		else $error("fill count differs from valid slots");

	// keys stay unique among valid slots
	a_single_match: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(match))
		else $error("key present in more than one slot");

	// a non-empty store always has exactly one least recent slot to evict
	a_victim_exists: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != '0) |-> $onehot(victim_vec))
		else $error("recency ranks are not a permutation");

	// a put always leaves the store non-empty
	a_put_leaves_key: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && is_put) |=> (count_q != '0))
		else $error("put left the store empty");

endmodule
